@@ design/tocu_pkg.sv @@
// shared types and constants for the tty output conversion unit
package tocu_pkg;

	// most result items one input item can cause
	localparam int unsigned MAX_RESULTS = 8;

	// configuration register indexes
	localparam logic [2:0] REG_RAW_MODE       = 3'd0;
	localparam logic [2:0] REG_CRMOD          = 3'd1;
	localparam logic [2:0] REG_EXPAND_TABS    = 3'd2;
	localparam logic [2:0] REG_NL_DELAY_MODE  = 3'd3;
	localparam logic [2:0] REG_TAB_DELAY_MODE = 3'd4;
	localparam logic [2:0] REG_CR_DELAY_MODE  = 3'd5;
	localparam logic [2:0] REG_VT_DELAY       = 3'd6;

	// ascii codes
	localparam logic [6:0] CH_BS    = 7'o010;
	localparam logic [6:0] CH_HT    = 7'o011;
	localparam logic [6:0] CH_LF    = 7'o012;
	localparam logic [6:0] CH_VT    = 7'o013;
	localparam logic [6:0] CH_FF    = 7'o014;
	localparam logic [6:0] CH_CR    = 7'o015;
	localparam logic [6:0] CH_SPACE = 7'o040;
	localparam logic [6:0] CH_TILDE = 7'o176;

	// delay mode codes
	localparam logic [1:0] NL_DLY_COLUMN = 2'd1;
	localparam logic [1:0] NL_DLY_SIX    = 2'd2;
	localparam logic [1:0] TAB_DLY_DIST  = 2'd1;
	localparam logic [1:0] CR_DLY_NONE   = 2'd0;
	localparam logic [1:0] CR_DLY_SHORT  = 2'd1;
	localparam logic [1:0] CR_DLY_MID    = 2'd2;
	localparam logic [1:0] CR_DLY_LONG   = 2'd3;

	// delay tick counts
	localparam logic [7:0] TICKS_CR_SHORT = 8'd5;
	localparam logic [7:0] TICKS_CR_MID   = 8'd10;
	localparam logic [7:0] TICKS_CR_LONG  = 8'd20;
	localparam logic [7:0] TICKS_NL_MIN   = 8'd6;
	localparam logic [7:0] TICKS_NL_BASE  = 8'd3;
	localparam logic [7:0] TICKS_VT       = 8'd127;
	localparam logic [7:0] TICKS_NONE     = 8'd0;

	// result kinds
	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_DELAY = 1'b1;

	typedef struct packed {
		logic       raw_mode;
		logic       crmod;
		logic       expand_tabs;
		logic [1:0] nl_delay_mode;
		logic [1:0] tab_delay_mode;
		logic [1:0] cr_delay_mode;
		logic       vt_delay;
	} cfg_t;

	// which planned result the datapath puts out
	typedef enum logic [2:0] {
		SEL_CH1 = 3'd0,
		SEL_D1  = 3'd1,
		SEL_CH2 = 3'd2,
		SEL_D2  = 3'd3,
		SEL_SP  = 3'd4
	} sel_t;

	typedef struct packed {
		logic latch;
		logic div;
		logic plan;
		logic emit;
		sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic has_d1;
		logic has_ch2;
		logic has_d2;
		logic expand;
		logic sp_last;
	} dp_stat_t;

endpackage

@@ design/tocu_cfg.sv @@
// configuration registers of the tty output conversion unit
module tocu_cfg import tocu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [1:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_mode       <= 1'b0;
			cfg_q.crmod          <= 1'b1;
			cfg_q.expand_tabs    <= 1'b0;
			cfg_q.nl_delay_mode  <= 2'd0;
			cfg_q.tab_delay_mode <= 2'd0;
			cfg_q.cr_delay_mode  <= 2'd0;
			cfg_q.vt_delay       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAW_MODE:       cfg_q.raw_mode       <= cfg_data[0];
				REG_CRMOD:          cfg_q.crmod          <= cfg_data[0];
				REG_EXPAND_TABS:    cfg_q.expand_tabs    <= cfg_data[0];
				REG_NL_DELAY_MODE:  cfg_q.nl_delay_mode  <= cfg_data;
				REG_TAB_DELAY_MODE: cfg_q.tab_delay_mode <= cfg_data;
				REG_CR_DELAY_MODE:  cfg_q.cr_delay_mode  <= cfg_data;
				REG_VT_DELAY:       cfg_q.vt_delay       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/tocu_dpath.sv @@
// datapath: column tracking, tab stop arithmetic, result planning and output register
module tocu_dpath import tocu_pkg::*; #(
	parameter int unsigned TAB_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic [7:0] out_byte,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic       item_ready,
	output logic       item_valid,
	output logic       item_kind,
	output logic [7:0] item_value,
	output logic       last
);

	// column / TAB_WIDTH by reciprocal multiplication, exact for 8-bit columns
	localparam int unsigned DIV_SHIFT = 16;
	localparam int unsigned RECIP     = (2**DIV_SHIFT + TAB_WIDTH - 1) / TAB_WIDTH;
	localparam int unsigned PROD_W    = DIV_SHIFT + 9;
	localparam int unsigned DIST_W    = $clog2(TAB_WIDTH + 1);

	logic [7:0]        byte_q;
	logic [7:0]        column_q;
	logic [PROD_W-1:0] prod_s1;
	logic [7:0]        ch1_q;
	logic [7:0]        d1_q;
	logic [7:0]        ch2_q;
	logic [7:0]        d2_q;
	logic              has_ch2_q;
	logic              expand_q;
	logic [3:0]        sp_cnt_q;
	logic              item_valid_q;
	logic              item_kind_q;
	logic [7:0]        item_value_q;
	logic              last_q;

	logic [6:0]        c;
	logic [7:0]        quot;
	logic [11:0]       quot_tw;
	logic [8:0]        rem;
	logic [DIST_W-1:0] stop_dist;
	logic [8:0]        room;
	logic [8:0]        nsp9;
	logic [7:0]        nl_hi;
	logic [7:0]        nl_col_dly;
	logic [7:0]        nl_dly;
	logic [7:0]        nl_dly_home;
	logic [7:0]        cr_dly;
	logic [7:0]        p_ch1;
	logic [7:0]        p_d1;
	logic [7:0]        p_ch2;
	logic [7:0]        p_d2;
	logic              p_has_ch2;
	logic              p_expand;
	logic [7:0]        p_col;

	logic              e_kind;
	logic [7:0]        e_value;
	logic              e_last;

	// input byte and column
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= out_byte;
		end
		if (cmd.div) begin
			prod_s1 <= PROD_W'(column_q) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 8'd0;
		end else if (cmd.plan) begin
			column_q <= p_col;
		end
	end

	// tab stop distance and delay values
	always_comb begin
		c         = byte_q[6:0];
		quot      = prod_s1[DIV_SHIFT +: 8];
		quot_tw   = 12'(quot) * 12'(TAB_WIDTH);
		rem       = {1'b0, column_q} - quot_tw[8:0];
		stop_dist = DIST_W'(9'(TAB_WIDTH) - rem);
		room      = 9'd256 - {1'b0, column_q};
		nsp9      = 9'(MAX_RESULTS);
		if (9'(stop_dist) < nsp9) begin
			nsp9 = 9'(stop_dist);
		end
		if (room < nsp9) begin
			nsp9 = room;
		end

		nl_hi = {4'd0, column_q[7:4]} + TICKS_NL_BASE;
		if (column_q == 8'd0) begin
			nl_col_dly = TICKS_NONE;
		end else if (nl_hi < TICKS_NL_MIN) begin
			nl_col_dly = TICKS_NL_MIN;
		end else begin
			nl_col_dly = nl_hi;
		end

		// newline delay at the current column and with the column already at zero
		if (cfg.nl_delay_mode == NL_DLY_COLUMN) begin
			nl_dly      = nl_col_dly;
			nl_dly_home = TICKS_NONE;
		end else if (cfg.nl_delay_mode == NL_DLY_SIX) begin
			nl_dly      = TICKS_NL_MIN;
			nl_dly_home = TICKS_NL_MIN;
		end else begin
			nl_dly      = TICKS_NONE;
			nl_dly_home = TICKS_NONE;
		end

		unique case (cfg.cr_delay_mode)
			CR_DLY_NONE:  cr_dly = TICKS_NONE;
			CR_DLY_SHORT: cr_dly = TICKS_CR_SHORT;
			CR_DLY_MID:   cr_dly = TICKS_CR_MID;
			CR_DLY_LONG:  cr_dly = TICKS_CR_LONG;
			default:      cr_dly = TICKS_NONE;
		endcase
	end

	// classify the byte and plan its results
	always_comb begin
		p_ch1     = {1'b0, c};
		p_d1      = TICKS_NONE;
		p_ch2     = {1'b0, CH_LF};
		p_d2      = TICKS_NONE;
		p_has_ch2 = 1'b0;
		p_expand  = 1'b0;
		p_col     = column_q;
		priority if (cfg.raw_mode) begin
			p_ch1 = byte_q;
		end else if (c >= CH_SPACE && c <= CH_TILDE) begin
			p_col = column_q + 8'd1;
		end else if (c == CH_BS) begin
			if (column_q != 8'd0) begin
				p_col = column_q - 8'd1;
			end
		end else if (c == CH_LF) begin
			p_col = 8'd0;
			if (cfg.crmod) begin
				p_ch1     = {1'b0, CH_CR};
				p_d1      = cr_dly;
				p_has_ch2 = 1'b1;
				p_d2      = nl_dly_home;
			end else begin
				p_d1 = nl_dly;
			end
		end else if (c == CH_HT) begin
			if (cfg.expand_tabs) begin
				p_expand = 1'b1;
				p_col    = column_q + nsp9[7:0];
			end else begin
				p_col = column_q + 8'(stop_dist);
				if (cfg.tab_delay_mode == TAB_DLY_DIST && 9'(stop_dist) >= 9'd4) begin
					p_d1 = 8'(stop_dist) + 8'd1;
				end
			end
		end else if (c == CH_VT || c == CH_FF) begin
			if (cfg.vt_delay) begin
				p_d1 = TICKS_VT;
			end
		end else if (c == CH_CR) begin
			p_d1  = cr_dly;
			p_col = 8'd0;
		end else begin
			p_ch1 = {1'b0, c};
		end
	end

	// planned results
	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			ch1_q     <= p_ch1;
			d1_q      <= p_d1;
			ch2_q     <= p_ch2;
			d2_q      <= p_d2;
			has_ch2_q <= p_has_ch2;
			expand_q  <= p_expand;
			sp_cnt_q  <= nsp9[3:0];
		end else if (cmd.emit && cmd.sel == SEL_SP) begin
			sp_cnt_q <= sp_cnt_q - 4'd1;
		end
	end

	// status for the controller
	always_comb begin
		stat.out_free = !item_valid_q || item_ready;
		stat.has_d1   = d1_q != TICKS_NONE;
		stat.has_ch2  = has_ch2_q;
		stat.has_d2   = d2_q != TICKS_NONE;
		stat.expand   = expand_q;
		stat.sp_last  = sp_cnt_q == 4'd1;
	end

	// select the result to put out
	always_comb begin
		unique case (cmd.sel)
			SEL_CH1: begin
				e_kind  = KIND_CHAR;
				e_value = ch1_q;
				e_last  = !stat.has_d1 && !has_ch2_q;
			end
			SEL_D1: begin
				e_kind  = KIND_DELAY;
				e_value = d1_q;
				e_last  = !has_ch2_q;
			end
			SEL_CH2: begin
				e_kind  = KIND_CHAR;
				e_value = ch2_q;
				e_last  = !stat.has_d2;
			end
			SEL_D2: begin
				e_kind  = KIND_DELAY;
				e_value = d2_q;
				e_last  = 1'b1;
			end
			SEL_SP: begin
				e_kind  = KIND_CHAR;
				e_value = {1'b0, CH_SPACE};
				e_last  = stat.sp_last;
			end
			default: begin
				e_kind  = KIND_CHAR;
				e_value = ch1_q;
				e_last  = 1'b1;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			item_valid_q <= 1'b1;
		end else if (item_ready) begin
			item_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			item_kind_q  <= e_kind;
			item_value_q <= e_value;
			last_q       <= e_last;
		end
	end

	assign item_valid = item_valid_q;
	assign item_kind  = item_kind_q;
	assign item_value = item_value_q;
	assign last       = last_q;

endmodule

@@ design/tocu_ctrl.sv @@
// controller: sequences division, planning and the results of one item
module tocu_ctrl import tocu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV  = 8'b0000_0010,
		S_PLAN = 8'b0000_0100,
		S_CH1  = 8'b0000_1000,
		S_D1   = 8'b0001_0000,
		S_CH2  = 8'b0010_0000,
		S_D2   = 8'b0100_0000,
		S_SP   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   emit_state;

	// next state and datapath commands
	always_comb begin
		state_d    = state_q;
		emit_state = 1'b0;
		cmd.latch  = 1'b0;
		cmd.div    = 1'b0;
		cmd.plan   = 1'b0;
		cmd.sel    = SEL_CH1;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = byte_valid;
				if (byte_valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				state_d = S_PLAN;
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = S_CH1;
			end
			S_CH1: begin
				emit_state = 1'b1;
				if (stat.expand) begin
					state_d = S_SP;
				end else if (stat.out_free) begin
					if (stat.has_d1) begin
						state_d = S_D1;
					end else if (stat.has_ch2) begin
						state_d = S_CH2;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_D1: begin
				emit_state = 1'b1;
				cmd.sel    = SEL_D1;
				if (stat.out_free) begin
					state_d = stat.has_ch2 ? S_CH2 : S_IDLE;
				end
			end
			S_CH2: begin
				emit_state = 1'b1;
				cmd.sel    = SEL_CH2;
				if (stat.out_free) begin
					state_d = stat.has_d2 ? S_D2 : S_IDLE;
				end
			end
			S_D2: begin
				emit_state = 1'b1;
				cmd.sel    = SEL_D2;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SP: begin
				emit_state = 1'b1;
				cmd.sel    = SEL_SP;
				if (stat.out_free && stat.sp_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// an expanded tab puts out nothing from the first-character state
		cmd.emit = emit_state && stat.out_free && !(state_q == S_CH1 && stat.expand);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign byte_ready = state_q == S_IDLE;

endmodule

@@ design/tty_output_conversion_unit.sv @@
// Terminal output conversion unit: top level joining registers, controller and datapath.
// The first result is registered after the column divide and plan states; an expanded tab
// also passes the first-character state, which puts out nothing. The single output register
// takes one result per cycle unless item_ready stalls it. An item causing 1 to 8 results
// holds byte_ready low until its last result is put out, so no new item is taken before that.
// Reset: arst_n clears the column to 0 and the registers to their reset values.
module tty_output_conversion_unit import tocu_pkg::*; #(
	parameter int unsigned TAB_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [1:0] cfg_data,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] out_byte,
	output logic       item_valid,
	input  logic       item_ready,
	output logic       item_kind,
	output logic [7:0] item_value,
	output logic       last
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// configuration registers
	tocu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencing
	tocu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// conversion datapath
	tocu_dpath #(
		.TAB_WIDTH (TAB_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.out_byte   (out_byte),
		.cmd        (cmd),
		.stat       (stat),
		.item_ready (item_ready),
		.item_valid (item_valid),
		.item_kind  (item_kind),
		.item_value (item_value),
		.last       (last)
	);

endmodule
